FILE: rtl/mva_pkg.sv
// Package for the quorum lock voter: sizes, command and reply codes, and the
// structs that travel between the controller and the chain of waiting cells.
// Depends on nothing.
package mva_pkg;

   localparam int WAIT_DEPTH = 8;
   localparam int STAMP_BITS = 16;
   localparam int ID_BITS    = 8;
   localparam int IDX_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

   localparam logic [1:0] CMD_REQUEST    = 2'd0;
   localparam logic [1:0] CMD_RELEASE    = 2'd1;
   localparam logic [1:0] CMD_RELINQUISH = 2'd2;

   localparam logic [1:0] KIND_GRANT   = 2'd0;
   localparam logic [1:0] KIND_FAIL    = 2'd1;
   localparam logic [1:0] KIND_INQUIRE = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [ID_BITS-1:0]    requester_id;
      logic [STAMP_BITS-1:0] stamp;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            reply_kind;
      logic [ID_BITS-1:0]    target_id;
      logic [STAMP_BITS-1:0] target_stamp;
   } rsp_item_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    key_id;
      logic                  subst;
      logic [STAMP_BITS-1:0] subst_stamp;
   } query_type;

   typedef struct packed {
      logic                  active;
      logic                  id_hit;
      logic [IDX_W-1:0]      id_slot;
      logic                  free_hit;
      logic [IDX_W-1:0]      free_slot;
      logic                  min_hit;
      logic [IDX_W-1:0]      min_slot;
      logic [ID_BITS-1:0]    min_id;
      logic [STAMP_BITS-1:0] min_stamp;
   } scan_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      slot;
      logic                  valid_val;
      logic                  load_id;
      logic [ID_BITS-1:0]    id;
      logic                  load_stamp;
      logic [STAMP_BITS-1:0] stamp;
   } wr_type;

endpackage

FILE: rtl/mva_cell.sv
// One waiting-table cell: holds one entry and adds it to the scan token that
// passes through it on the way to the next cell. Depends on mva_pkg.
module mva_cell
   import mva_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] slot_index,
   input  query_type        query,
   input  scan_type         scan_in,
   input  wr_type           wr_a,
   input  wr_type           wr_b,
   output scan_type         scan_out
);

   logic                  valid_ff, valid_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   scan_type              scan_ff, scan_in_next;
   logic                  match;
   logic [STAMP_BITS-1:0] eff_stamp;

   always_comb begin
      match     = valid_ff && (id_ff == query.key_id);
      eff_stamp = (query.subst && match) ? query.subst_stamp : stamp_ff;
      scan_in_next = scan_in;
      if (match && !scan_in.id_hit) begin
         scan_in_next.id_hit  = 1'b1;
         scan_in_next.id_slot = slot_index;
      end
      if (!valid_ff && !scan_in.free_hit) begin
         scan_in_next.free_hit  = 1'b1;
         scan_in_next.free_slot = slot_index;
      end
      if (valid_ff && (!scan_in.min_hit || (eff_stamp < scan_in.min_stamp))) begin
         scan_in_next.min_hit   = 1'b1;
         scan_in_next.min_slot  = slot_index;
         scan_in_next.min_id    = id_ff;
         scan_in_next.min_stamp = eff_stamp;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      stamp_in = stamp_ff;
      if (wr_a.en && (wr_a.slot == slot_index)) begin
         valid_in = wr_a.valid_val;
         if (wr_a.load_id) begin
            id_in = wr_a.id;
         end
         if (wr_a.load_stamp) begin
            stamp_in = wr_a.stamp;
         end
      end
      if (wr_b.en && (wr_b.slot == slot_index)) begin
         valid_in = wr_b.valid_val;
         if (wr_b.load_id) begin
            id_in = wr_b.id;
         end
         if (wr_b.load_stamp) begin
            stamp_in = wr_b.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         scan_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         scan_ff  <= scan_in_next;
      end
      id_ff    <= id_in;
      stamp_ff <= stamp_in;
   end

   assign scan_out = scan_ff;

endmodule

FILE: rtl/mutex_vote_arbiter.sv
// Top level of the quorum lock voter: command controller, vote holder state
// and the chain of waiting-table cells. Depends on mva_pkg and mva_cell.
//
// Usage: drive req_item and raise start; the request is taken at a rising
// edge where start is high and busy is low. Every request yields exactly one
// result, shown on rsp_item for a single cycle with rsp_valid high.
// The request enters a scan token that walks the chain of WAIT_DEPTH cells,
// one cell per cycle; at the edge where it leaves the last cell the table
// and vote are updated and the result is registered. Latency from accept to
// rsp_valid is WAIT_DEPTH + 2 cycles (10 for eight entries), and busy is high
// for WAIT_DEPTH + 1 cycles, so a new request may be taken in the cycle the
// result is shown: one request per WAIT_DEPTH + 2 cycles sustained. The
// cell chain length sets this figure.
// Synchronous reset frees the vote, empties the table and drops any request
// in flight. The receiver cannot stall; it must take rsp_item when shown.
module mutex_vote_arbiter
   import mva_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic                  inject_ff, inject_in;
   req_item_type          cur_ff, cur_in;
   query_type             query_ff, query_in;
   logic                  vote_ff, vote_in;
   logic [ID_BITS-1:0]    holder_id_ff, holder_id_in;
   logic [STAMP_BITS-1:0] holder_stamp_ff, holder_stamp_in;
   logic                  inq_ff, inq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;
   logic                  accept;
   scan_type              chain [0:WAIT_DEPTH];
   scan_type              fin;
   wr_type                wr_a, wr_b;
   logic [IDX_W-1:0]      req_slot;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      chain[0]        = '0;
      chain[0].active = inject_ff;
   end

   for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
      mva_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .slot_index (IDX_W'(i)),
         .query      (query_ff),
         .scan_in    (chain[i]),
         .wr_a       (wr_a),
         .wr_b       (wr_b),
         .scan_out   (chain[i+1])
      );
   end

   assign fin = chain[WAIT_DEPTH];

   always_comb begin
      state_in        = state_ff;
      inject_in       = 1'b0;
      cur_in          = cur_ff;
      query_in        = query_ff;
      vote_in         = vote_ff;
      holder_id_in    = holder_id_ff;
      holder_stamp_in = holder_stamp_ff;
      inq_in          = inq_ff;
      rsp_valid_in    = 1'b0;
      rsp_item_in     = rsp_item_ff;
      wr_a            = '0;
      wr_b            = '0;
      req_slot        = fin.id_hit ? fin.id_slot : fin.free_slot;

      if (accept) begin
         state_in             = ST_SCAN;
         inject_in            = 1'b1;
         cur_in               = req_item;
         query_in.subst       = (req_item.cmd == CMD_RELINQUISH);
         query_in.subst_stamp = holder_stamp_ff;
         query_in.key_id      = (req_item.cmd == CMD_RELINQUISH) ?
                                holder_id_ff : req_item.requester_id;
      end

      if ((state_ff == ST_SCAN) && fin.active) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_item_in  = '{KIND_NONE, '0, '0};
         case (cur_ff.cmd)
            CMD_REQUEST: begin
               if (!vote_ff) begin
                  vote_in         = 1'b1;
                  holder_id_in    = cur_ff.requester_id;
                  holder_stamp_in = cur_ff.stamp;
                  rsp_item_in     = '{KIND_GRANT, cur_ff.requester_id, cur_ff.stamp};
               end else if (!fin.id_hit && !fin.free_hit) begin
                  rsp_item_in = '{KIND_FAIL, cur_ff.requester_id, cur_ff.stamp};
               end else begin
                  wr_a.en         = 1'b1;
                  wr_a.slot       = req_slot;
                  wr_a.valid_val  = 1'b1;
                  wr_a.load_id    = !fin.id_hit;
                  wr_a.id         = cur_ff.requester_id;
                  wr_a.load_stamp = 1'b1;
                  wr_a.stamp      = cur_ff.stamp;
                  if ((cur_ff.stamp < holder_stamp_ff) && !inq_ff) begin
                     inq_in      = 1'b1;
                     rsp_item_in = '{KIND_INQUIRE, holder_id_ff, holder_stamp_ff};
                  end else begin
                     rsp_item_in = '{KIND_FAIL, cur_ff.requester_id, cur_ff.stamp};
                  end
               end
            end
            CMD_RELEASE: begin
               inq_in = 1'b0;
               if (!fin.min_hit) begin
                  vote_in = 1'b0;
               end else begin
                  vote_in         = 1'b1;
                  holder_id_in    = fin.min_id;
                  holder_stamp_in = fin.min_stamp;
                  wr_b.en         = 1'b1;
                  wr_b.slot       = fin.min_slot;
                  wr_b.valid_val  = 1'b0;
                  rsp_item_in     = '{KIND_GRANT, fin.min_id, fin.min_stamp};
               end
            end
            CMD_RELINQUISH: begin
               inq_in = 1'b0;
               if (vote_ff) begin
                  if (fin.id_hit) begin
                     wr_a.en         = 1'b1;
                     wr_a.slot       = fin.id_slot;
                     wr_a.valid_val  = 1'b1;
                     wr_a.load_stamp = 1'b1;
                     wr_a.stamp      = holder_stamp_ff;
                     wr_b.en         = 1'b1;
                     wr_b.slot       = fin.min_slot;
                     wr_b.valid_val  = 1'b0;
                     holder_id_in    = fin.min_id;
                     holder_stamp_in = fin.min_stamp;
                     rsp_item_in     = '{KIND_GRANT, fin.min_id, fin.min_stamp};
                  end else if (!fin.min_hit || (holder_stamp_ff <= fin.min_stamp)) begin
                     rsp_item_in = '{KIND_GRANT, holder_id_ff, holder_stamp_ff};
                  end else begin
                     wr_a.en         = 1'b1;
                     wr_a.slot       = fin.min_slot;
                     wr_a.valid_val  = 1'b1;
                     wr_a.load_id    = 1'b1;
                     wr_a.id         = holder_id_ff;
                     wr_a.load_stamp = 1'b1;
                     wr_a.stamp      = holder_stamp_ff;
                     holder_id_in    = fin.min_id;
                     holder_stamp_in = fin.min_stamp;
                     rsp_item_in     = '{KIND_GRANT, fin.min_id, fin.min_stamp};
                  end
               end
            end
            default: begin
               rsp_item_in = '{KIND_NONE, '0, '0};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         inject_ff       <= 1'b0;
         vote_ff         <= 1'b0;
         holder_id_ff    <= '0;
         holder_stamp_ff <= '0;
         inq_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         inject_ff       <= inject_in;
         vote_ff         <= vote_in;
         holder_id_ff    <= holder_id_in;
         holder_stamp_ff <= holder_stamp_in;
         inq_ff          <= inq_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      query_ff    <= query_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Accepted request did not raise busy.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe lasted more than one cycle.");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result shown while a request is still in flight.");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      fin.active |-> (state_ff == ST_SCAN))
      else $error("Scan token left the chain outside a scan.");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.reply_kind == KIND_NONE)) |->
      ((rsp_item.target_id == '0) && (rsp_item.target_stamp == '0)))
      else $error("Empty reply carries a nonzero target.");

endmodule

FILE: test/tb_mutex_vote_arbiter.sv
// Self-checking testbench for the quorum lock voter mutex_vote_arbiter.
// Drives directed and random request streams with bursty gaps and checks every reply
// against a behavioral model of the vote and waiting table; depends on mva_pkg.
`timescale 1ns / 1ps

module tb_mutex_vote_arbiter;
   import mva_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 1650;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 30;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   req_item_type req_backlog[$];
   rsp_item_type reply_due[$];

   logic                  vote_out;
   logic [ID_BITS-1:0]    holder_pid;
   logic [STAMP_BITS-1:0] holder_ts;
   logic                  inquiry_out;
   logic                  slot_used[WAIT_DEPTH];
   logic [ID_BITS-1:0]    slot_pid[WAIT_DEPTH];
   logic [STAMP_BITS-1:0] slot_ts[WAIT_DEPTH];

   int err_count = 0;
   int replies_seen = 0;
   int cmd_count[4] = '{0, 0, 0, 0};
   int kind_count[4] = '{0, 0, 0, 0};
   int burst_left = 1;
   int gap_left = 0;
   int idle_cycles = 0;

   mutex_vote_arbiter uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_item_type make_reply(logic [1:0] kind, logic [ID_BITS-1:0] id,
                                               logic [STAMP_BITS-1:0] ts);
      rsp_item_type y;
      y.reply_kind = kind;
      y.target_id = id;
      y.target_stamp = ts;
      return y;
   endfunction

   function automatic int slot_of(logic [ID_BITS-1:0] id);
      for (int i = 0; i < WAIT_DEPTH; i++)
         if (slot_used[i] && slot_pid[i] == id) return i;
      return -1;
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < WAIT_DEPTH; i++)
         if (!slot_used[i]) return i;
      return -1;
   endfunction

   function automatic int oldest_slot();
      int best;
      best = -1;
      for (int i = 0; i < WAIT_DEPTH; i++)
         if (slot_used[i] && (best < 0 || slot_ts[i] < slot_ts[best])) best = i;
      return best;
   endfunction

   function automatic rsp_item_type hand_vote_to(int s);
      holder_pid = slot_pid[s];
      holder_ts = slot_ts[s];
      slot_used[s] = 1'b0;
      vote_out = 1'b1;
      return make_reply(KIND_GRANT, holder_pid, holder_ts);
   endfunction

   function automatic rsp_item_type vote_reply(req_item_type r);
      int s;
      int m;
      logic [ID_BITS-1:0]    swap_pid;
      logic [STAMP_BITS-1:0] swap_ts;
      case (r.cmd)
         CMD_REQUEST: begin
            if (!vote_out) begin
               vote_out = 1'b1;
               holder_pid = r.requester_id;
               holder_ts = r.stamp;
               return make_reply(KIND_GRANT, r.requester_id, r.stamp);
            end
            s = slot_of(r.requester_id);
            if (s < 0) s = free_slot();
            if (s < 0) return make_reply(KIND_FAIL, r.requester_id, r.stamp);
            slot_used[s] = 1'b1;
            slot_pid[s] = r.requester_id;
            slot_ts[s] = r.stamp;
            if (r.stamp < holder_ts && !inquiry_out) begin
               inquiry_out = 1'b1;
               return make_reply(KIND_INQUIRE, holder_pid, holder_ts);
            end
            return make_reply(KIND_FAIL, r.requester_id, r.stamp);
         end
         CMD_RELEASE: begin
            inquiry_out = 1'b0;
            m = oldest_slot();
            if (m < 0) begin
               vote_out = 1'b0;
               return make_reply(KIND_NONE, '0, '0);
            end
            return hand_vote_to(m);
         end
         CMD_RELINQUISH: begin
            inquiry_out = 1'b0;
            if (!vote_out) return make_reply(KIND_NONE, '0, '0);
            s = slot_of(holder_pid);
            if (s >= 0) begin
               slot_ts[s] = holder_ts;
               return hand_vote_to(oldest_slot());
            end
            m = oldest_slot();
            if (m < 0 || holder_ts <= slot_ts[m])
               return make_reply(KIND_GRANT, holder_pid, holder_ts);
            swap_pid = slot_pid[m];
            swap_ts = slot_ts[m];
            slot_pid[m] = holder_pid;
            slot_ts[m] = holder_ts;
            holder_pid = swap_pid;
            holder_ts = swap_ts;
            return make_reply(KIND_GRANT, holder_pid, holder_ts);
         end
         default: return make_reply(KIND_NONE, '0, '0);
      endcase
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      $display("mismatch at reply %0d: %s expected %0d got %0d", replies_seen, what, want,
               got);
      err_count++;
   endtask

   task automatic queue_item(logic [1:0] cmd, int unsigned id, int unsigned ts);
      req_item_type r;
      r.cmd = cmd;
      r.requester_id = id[ID_BITS-1:0];
      r.stamp = ts[STAMP_BITS-1:0];
      req_backlog.push_back(r);
   endtask

   always @(posedge clock) begin
      logic fire;
      if (reset) begin
         start <= 1'b0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
               if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(15, 40);
            end
         end
         if (fire || !start) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_item <= req_backlog.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (reply_due.size() == 0) begin
               report_mismatch("reply with nothing outstanding, kind", 0, rsp_item.reply_kind);
            end else begin
               want = reply_due.pop_front();
               if (rsp_item.reply_kind !== want.reply_kind)
                  report_mismatch("reply_kind", want.reply_kind, rsp_item.reply_kind);
               if (rsp_item.target_id !== want.target_id)
                  report_mismatch("target_id", want.target_id, rsp_item.target_id);
               if (rsp_item.target_stamp !== want.target_stamp)
                  report_mismatch("target_stamp", want.target_stamp, rsp_item.target_stamp);
               kind_count[want.reply_kind]++;
            end
            replies_seen++;
         end
         if (start && !busy) begin
            reply_due.push_back(vote_reply(req_item));
            cmd_count[req_item.cmd]++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d replies still outstanding", reply_due.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int pool;
      int id_base;
      int span;
      int ts_base;
      int req_weight;
      int phase_len;
      int made;
      int pick;
      int unsigned id;

      vote_out = 1'b0;
      holder_pid = '0;
      holder_ts = '0;
      inquiry_out = 1'b0;
      for (int i = 0; i < WAIT_DEPTH; i++) begin
         slot_used[i] = 1'b0;
         slot_pid[i] = '0;
         slot_ts[i] = '0;
      end

      queue_item(CMD_RELEASE, 8'hA5, 16'h5A5A);
      queue_item(CMD_RELINQUISH, 8'h5A, 16'hA5A5);
      queue_item(CMD_UNKNOWN, 255, 65535);
      queue_item(CMD_REQUEST, 0, 0);
      queue_item(CMD_REQUEST, 255, 65535);
      queue_item(CMD_RELINQUISH, 0, 0);
      queue_item(CMD_RELEASE, 0, 0);
      queue_item(CMD_REQUEST, 5, 100);
      queue_item(CMD_REQUEST, 6, 50);
      queue_item(CMD_REQUEST, 5, 30);
      queue_item(CMD_RELINQUISH, 0, 0);
      queue_item(CMD_REQUEST, 7, 30);
      queue_item(CMD_REQUEST, 5, 40);
      queue_item(CMD_RELINQUISH, 0, 0);
      for (int i = 20; i <= 25; i++) queue_item(CMD_REQUEST, i, 1000);
      queue_item(CMD_REQUEST, 26, 0);
      queue_item(CMD_REQUEST, 20, 0);
      queue_item(CMD_RELEASE, 0, 0);

      made = 0;
      while (made < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: pool = 4;
            1: pool = 9;
            2: pool = 16;
            default: pool = 256;
         endcase
         case ($urandom_range(0, 2))
            0: span = 16;
            1: span = 256;
            default: span = 65536;
         endcase
         id_base = $urandom_range(0, 255);
         ts_base = $urandom_range(0, 65535);
         req_weight = $urandom_range(40, 80);
         phase_len = $urandom_range(40, 120);
         for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            id = (pool == 256) ? $urandom_range(0, 255)
                               : id_base + $urandom_range(0, pool - 1);
            if (pick < req_weight)
               queue_item(CMD_REQUEST, id, ts_base + $urandom_range(0, span - 1));
            else if (pick < 96)
               queue_item($urandom_range(0, 1) ? CMD_RELEASE : CMD_RELINQUISH,
                          $urandom_range(0, 255), $urandom_range(0, 65535));
            else
               queue_item(CMD_UNKNOWN, $urandom_range(0, 255), $urandom_range(0, 65535));
            made++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (req_backlog.size() > 0 || start || reply_due.size() > 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("commands taken: %0d request, %0d release, %0d relinquish, %0d unknown",
               cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
      $display("replies checked: %0d grant, %0d fail, %0d inquire, %0d none; %0d errors",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3], err_count);
      if (err_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
